// File: src/mct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_pkg
// Types, tables and constants shared by the cell triangulator modules.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int MAX_RES = 512;

  localparam int CORNER_W = 16;
  localparam int VOXEL_W  = 9;
  localparam int ISO_W    = 14;
  localparam int SIZE_W   = 24;
  localparam int COORD_W  = 33;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int DIGITS_W = 60;
  localparam int NUM_W    = 17;
  localparam int PROD_W   = SIZE_W + NUM_W;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_ISO_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Y = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE_Z = 2'd3;

  localparam logic [ISO_W-1:0]  ISO_RESET  = 14'd0;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 24'd65536;

  // axis along which an edge runs
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [3:0] LAST_EDGE  = 4'd11;
  localparam logic [3:0] ROW_MARK   = 4'hF;

  typedef struct packed {
    logic signed [CORNER_W-1:0] corner_0;
    logic signed [CORNER_W-1:0] corner_1;
    logic signed [CORNER_W-1:0] corner_2;
    logic signed [CORNER_W-1:0] corner_3;
    logic signed [CORNER_W-1:0] corner_4;
    logic signed [CORNER_W-1:0] corner_5;
    logic signed [CORNER_W-1:0] corner_6;
    logic signed [CORNER_W-1:0] corner_7;
    logic [VOXEL_W-1:0]         voxel_x;
    logic [VOXEL_W-1:0]         voxel_y;
    logic [VOXEL_W-1:0]         voxel_z;
    logic                       all_observed;
  } cell_t;

  typedef struct packed {
    logic [COORD_W-1:0] vertex_x;
    logic [COORD_W-1:0] vertex_y;
    logic [COORD_W-1:0] vertex_z;
    logic               last_vertex;
  } vertex_t;

  // request handed from the front to the back
  typedef struct packed {
    logic [7:0][CORNER_W-1:0] corners;
    logic [COORD_W-1:0]       base_x;
    logic [COORD_W-1:0]       base_y;
    logic [COORD_W-1:0]       base_z;
    logic [DIGITS_W-1:0]      digits;
    logic [3:0]               len;
  } entry_t;

  // edge endpoints, lower corner first
  localparam logic [2:0] EDGE_LO [12] = '{3'd0, 3'd1, 3'd3, 3'd0, 3'd4, 3'd5,
                                           3'd7, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
  localparam logic [2:0] EDGE_HI [12] = '{3'd1, 3'd2, 3'd2, 3'd3, 3'd5, 3'd6,
                                           3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7};
  localparam logic [1:0] EDGE_AXIS [12] = '{AXIS_X, AXIS_Z, AXIS_X, AXIS_Z,
                                             AXIS_X, AXIS_Z, AXIS_X, AXIS_Z,
                                             AXIS_Y, AXIS_Y, AXIS_Y, AXIS_Y};

  function automatic logic corner_x(input logic [2:0] c);
    return c[0] ^ c[1];
  endfunction

  function automatic logic corner_y(input logic [2:0] c);
    return c[2];
  endfunction

  function automatic logic corner_z(input logic [2:0] c);
    return c[1];
  endfunction

  // triangle rows: marker nibble F, then edge digits, first edge highest
  localparam logic [63:0] TRI_ROM [256] = '{
    64'hF, 64'hF083, 64'hF019, 64'hF183981, 64'hF12a, 64'hF08312a, 64'hF92a029,
    64'hF2832a8a98, 64'hF3b2, 64'hF0b28b0, 64'hF19023b, 64'hF1b219b98b,
    64'hF3a1ba3, 64'hF0a108a8ba, 64'hF3903b9ba9, 64'hF98aa8b,
    64'hF478, 64'hF430734, 64'hF019847, 64'hF419471731, 64'hF12a847,
    64'hF34730412a, 64'hF92a902847, 64'hF2a9297273794, 64'hF8473b2,
    64'hFb47b24204, 64'hF90184723b, 64'hF47b94b9b2921, 64'hF3a13ba784,
    64'hF1ba14b1047b4, 64'hF47890b9bab03, 64'hF47b4b99ba,
    64'hF954, 64'hF954083, 64'hF054150, 64'hF854835315, 64'hF12a954,
    64'hF30812a495, 64'hF52a542402, 64'hF2a5325354348, 64'hF95423b,
    64'hF0b208b495, 64'hF05401523b, 64'hF21525828b485, 64'hFa3ba13954,
    64'hF4950818a18ba, 64'hF54050b5bab03, 64'hF54858aa8b,
    64'hF978579, 64'hF930953573, 64'hF078017157, 64'hF153357, 64'hF978957a12,
    64'hFa12950530573, 64'hF802825857a52, 64'hF2a5253357, 64'hF7957893b2,
    64'hF95797292027b, 64'hF23b018178157, 64'hFb21b17715, 64'hF958857a13a3b,
    64'hF5705097b010aba0, 64'hFba0b03a50807570, 64'hFba57b5,
    64'hFa65, 64'hF0835a6, 64'hF9015a6, 64'hF1831985a6, 64'hF165261,
    64'hF165126308, 64'hF965906026, 64'hF598582526328, 64'hF23ba65,
    64'hFb08b20a65, 64'hF01923b5a6, 64'hF5a61929b298b, 64'hF63b653513,
    64'hF08b0b50515b6, 64'hF3b6036065059, 64'hF65969bb98,
    64'hF5a6478, 64'hF43047365a, 64'hF1905a6847, 64'hFa65197173794,
    64'hF612651478, 64'hF125526304347, 64'hF847905065026,
    64'hF739794329596269, 64'hF3b2784a65, 64'hF5a647242027b,
    64'hF01947823b5a6, 64'hF9219b294b7b45a6, 64'hF8473b53515b6,
    64'hF51b5b610b7b404b, 64'hF059065036b63847, 64'hF65969b4797b9,
    64'hFa4964a, 64'hF4a649a083, 64'hFa01a60640, 64'hF83181686461a,
    64'hF149124264, 64'hF308129249264, 64'hF024426, 64'hF832824426,
    64'hFa49a64b23, 64'hF08228b49a4a6, 64'hF3b201606461a,
    64'hF64161a48121b8b1, 64'hF964936913b63, 64'hF8b1810b61914641,
    64'hF3b6360064, 64'hF648b68,
    64'hF7a678a89a, 64'hF0730a709a67a, 64'hFa671a7178180, 64'hFa67a71173,
    64'hF126168189867, 64'hF269291679093739, 64'hF780706602, 64'hF732672,
    64'hF23ba68a89867, 64'hF20727b09767a9a7, 64'hF1801781a767a23b,
    64'hFb21b17a61671, 64'hF896867916b63136, 64'hF091b67, 64'hF7807063b0b60,
    64'hF7b6,
    64'hF76b, 64'hF308b76, 64'hF019b76, 64'hF819831b76, 64'hFa1267b,
    64'hF12a3086b7, 64'hF2902a96b7, 64'hF6b72a3a83a98, 64'hF723627,
    64'hF708760620, 64'hF276237019, 64'hF162186198876, 64'hFa76a17137,
    64'hFa7617a187108, 64'hF03707a0a96a7, 64'hF76a7a88a9,
    64'hF684b86, 64'hF36b306046, 64'hF86b846901, 64'hF946963931b36,
    64'hF6846b82a1, 64'hF12a30b06b046, 64'hF4b846b0292a9,
    64'hFa93a32943b36463, 64'hF823842462, 64'hF042462, 64'hF190234246438,
    64'hF194142246, 64'hF8138618466a1, 64'hFa10a06604, 64'hF4634386a3039a93,
    64'hFa946a4,
    64'hF49576b, 64'hF083495b76, 64'hF50154076b, 64'hFb76834354315,
    64'hF954a1276b, 64'hF6b712a083495, 64'hF76b54a42a402,
    64'hF348354325a52b76, 64'hF723762549, 64'hF954086062687,
    64'hF362376150540, 64'hF628687218485158, 64'hF954a16176137,
    64'hF16a176107870954, 64'hF40a4a503a6a737a, 64'hF76a7a854a48a,
    64'hF6956b9b89, 64'hF36b063056095, 64'hF0b805b01556b, 64'hF6b3635531,
    64'hF12a95b9b8b56, 64'hF0b306b09656912a, 64'hFb85b56805a52025,
    64'hF6b36352a3a53, 64'hF589528562382, 64'hF956960062,
    64'hF158180568382628, 64'hF156216, 64'hF13616a386569896,
    64'hFa10a06950560, 64'hF03856a, 64'hFa56,
    64'hFb5a75b, 64'hFb5ab75830, 64'hF5b75ab190, 64'hFa75ab7981831,
    64'hFb12b71751, 64'hF08312717572b, 64'hF9759279022b7,
    64'hF75272b592328982, 64'hF25a235375, 64'hF820852875a25,
    64'hF9015a35373a2, 64'hF982921872a25752, 64'hF135375, 64'hF087071175,
    64'hF903935537, 64'hF987597,
    64'hF5845a8ab8, 64'hF5045b05abb30, 64'hF01984a8aba45,
    64'hFab4a45b34941314, 64'hF2512852b8458, 64'hF04b0b345b2b151b,
    64'hF0250592b5458b85, 64'hF9452b3, 64'hF25a352345384, 64'hF5a2524420,
    64'hF3a235a385458019, 64'hF5a2524192942, 64'hF845853351, 64'hF045105,
    64'hF845853905035, 64'hF945,
    64'hF4b749b9ab, 64'hF0834979b79ab, 64'hF1ab1b414074b,
    64'hF3143481a474bab4, 64'hF4b79b492b912, 64'hF9749b791b2b1083,
    64'hFb74b42240, 64'hFb74b42834324, 64'hF29a279237749,
    64'hF9a7974a27870207, 64'hF37a3a274a1a040a, 64'hF1a2874,
    64'hF491417713, 64'hF491417081871, 64'hF403743, 64'hF487,
    64'hF9a8ab8, 64'hF30939bb9a, 64'hF01a0a88ab, 64'hF31ab3a, 64'hF12b1b99b8,
    64'hF30939b1292b9, 64'hF02b80b, 64'hF32b, 64'hF23828aa89, 64'hF9a2092,
    64'hF23828a0181a8, 64'hF1a2, 64'hF138918, 64'hF091, 64'hF038, 64'hF
  };

endpackage

// File: src/mct_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_front
// Takes cells, builds the corner mask, looks up the triangle row and the
// cell base position, and queues cells that produce vertices.
// ----------------------------------------------------------------------------
module mct_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  mct_pkg::cell_t                  voxel,
  output logic                            busy,
  input  logic [mct_pkg::ISO_W-1:0]       iso_level,
  input  logic [mct_pkg::SIZE_W-1:0]      cell_size_x,
  input  logic [mct_pkg::SIZE_W-1:0]      cell_size_y,
  input  logic [mct_pkg::SIZE_W-1:0]      cell_size_z,
  output logic                            push,
  output mct_pkg::entry_t                 push_data,
  input  logic                            full
);

  logic           s1_valid;
  mct_pkg::cell_t s1_cell;
  logic [7:0][mct_pkg::CORNER_W-1:0] corners;
  logic [7:0]     mask;
  logic [63:0]    row;
  logic [3:0]     len;
  logic           in_range;
  logic           needs_push;

  assign corners = {s1_cell.corner_7, s1_cell.corner_6, s1_cell.corner_5,
                    s1_cell.corner_4, s1_cell.corner_3, s1_cell.corner_2,
                    s1_cell.corner_1, s1_cell.corner_0};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = $signed({corners[i][mct_pkg::CORNER_W-1], corners[i]}) <
                $signed({3'b000, iso_level});
    end
  end

  assign row = mct_pkg::TRI_ROM[mask];

  // digit count = position of the marker nibble
  always_comb begin
    len = 4'd0;
    for (int p = 0; p < 16; p++) begin
      if (row[4*p +: 4] == mct_pkg::ROW_MARK) begin
        len = 4'(p);
      end
    end
  end

  assign in_range = (32'(s1_cell.voxel_x) < 32'(mct_pkg::MAX_RES)) &&
                    (32'(s1_cell.voxel_y) < 32'(mct_pkg::MAX_RES)) &&
                    (32'(s1_cell.voxel_z) < 32'(mct_pkg::MAX_RES));

  assign needs_push = s1_cell.all_observed && in_range && (len != 4'd0);
  assign busy       = s1_valid && needs_push && full;
  assign push       = s1_valid && needs_push && !full;

  always_comb begin
    push_data.corners = corners;
    push_data.base_x  = mct_pkg::COORD_W'(s1_cell.voxel_x) *
                        mct_pkg::COORD_W'(cell_size_x);
    push_data.base_y  = mct_pkg::COORD_W'(s1_cell.voxel_y) *
                        mct_pkg::COORD_W'(cell_size_y);
    push_data.base_z  = mct_pkg::COORD_W'(s1_cell.voxel_z) *
                        mct_pkg::COORD_W'(cell_size_z);
    push_data.digits  = row[mct_pkg::DIGITS_W-1:0];
    push_data.len     = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!busy) begin
      s1_valid <= start;
    end
    if (start && !busy) begin
      s1_cell <= voxel;
    end
  end

endmodule

// File: src/mct_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_fifo
// Two-entry queue of cell requests between the front and the back.
// ----------------------------------------------------------------------------
module mct_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mct_pkg::entry_t push_data,
  input  logic            pop,
  output mct_pkg::entry_t pop_data,
  output logic            full,
  output logic            empty
);

  mct_pkg::entry_t mem [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: src/mct_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_back
// Walks the edge digits of a queued cell, interpolates each crossing with a
// one-bit-per-cycle divider and emits the vertices.
// ----------------------------------------------------------------------------
module mct_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mct_pkg::ISO_W-1:0]  iso_level,
  input  logic [mct_pkg::SIZE_W-1:0] cell_size_x,
  input  logic [mct_pkg::SIZE_W-1:0] cell_size_y,
  input  logic [mct_pkg::SIZE_W-1:0] cell_size_z,
  input  logic                       empty,
  input  mct_pkg::entry_t            pop_data,
  output logic                       pop,
  output logic                       vertex_valid,
  output mct_pkg::vertex_t           vertex
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  mct_pkg::entry_t             cur;
  logic [mct_pkg::DIGITS_W-1:0] dig;
  logic [3:0]                  cnt;
  logic [4:0]                  dcnt;

  logic [mct_pkg::NUM_W-1:0]   num_r;
  logic [mct_pkg::NUM_W-1:0]   den_r;
  logic [mct_pkg::SIZE_W-1:0]  size_r;
  logic [1:0]                  axis_r;
  logic [2:0]                  lo_r;
  logic                        zero_r;
  logic [mct_pkg::NUM_W-1:0]   rem;
  logic [mct_pkg::SIZE_W-1:0]  pr;

  // setup path
  logic [3:0]                  edge_code;
  logic [3:0]                  edge_idx;
  logic [2:0]                  lo;
  logic [2:0]                  hi;
  logic [1:0]                  axis;
  logic signed [17:0]          num_s;
  logic signed [17:0]          den_s;
  logic signed [17:0]          num_a;
  logic signed [17:0]          den_a;
  logic [mct_pkg::NUM_W-1:0]   num_c;
  logic [mct_pkg::PROD_W-1:0]  prod;
  logic [mct_pkg::NUM_W:0]     trial;
  logic                        ge;
  logic [mct_pkg::SIZE_W-1:0]  q;
  logic [mct_pkg::COORD_W-1:0] vx;
  logic [mct_pkg::COORD_W-1:0] vy;
  logic [mct_pkg::COORD_W-1:0] vz;

  assign edge_code = dig[mct_pkg::DIGITS_W-1 -: 4];
  assign edge_idx  = (edge_code > mct_pkg::LAST_EDGE) ? 4'd0 : edge_code;
  assign lo        = mct_pkg::EDGE_LO[edge_idx];
  assign hi        = mct_pkg::EDGE_HI[edge_idx];
  assign axis      = mct_pkg::EDGE_AXIS[edge_idx];

  always_comb begin
    num_s = $signed({4'b0000, iso_level}) -
            $signed({{2{cur.corners[lo][15]}}, cur.corners[lo]});
    den_s = $signed({{2{cur.corners[hi][15]}}, cur.corners[hi]}) -
            $signed({{2{cur.corners[lo][15]}}, cur.corners[lo]});
    num_a = den_s[17] ? -num_s : num_s;
    den_a = den_s[17] ? -den_s : den_s;
    if (num_a[17]) begin
      num_c = '0;
    end else if (num_a > den_a) begin
      num_c = den_a[mct_pkg::NUM_W-1:0];
    end else begin
      num_c = num_a[mct_pkg::NUM_W-1:0];
    end
  end

  assign prod  = mct_pkg::PROD_W'(size_r) * mct_pkg::PROD_W'(num_r);
  assign trial = {rem, pr[mct_pkg::SIZE_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign q     = zero_r ? '0 : pr;

  always_comb begin
    vx = cur.base_x + (mct_pkg::corner_x(lo_r) ?
                       mct_pkg::COORD_W'(cell_size_x) : '0);
    vy = cur.base_y + (mct_pkg::corner_y(lo_r) ?
                       mct_pkg::COORD_W'(cell_size_y) : '0);
    vz = cur.base_z + (mct_pkg::corner_z(lo_r) ?
                       mct_pkg::COORD_W'(cell_size_z) : '0);
    unique case (axis_r)
      mct_pkg::AXIS_X: vx = vx + mct_pkg::COORD_W'(q);
      mct_pkg::AXIS_Y: vy = vy + mct_pkg::COORD_W'(q);
      default:         vz = vz + mct_pkg::COORD_W'(q);
    endcase
  end

  assign pop = (state == ST_IDLE) && !empty;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!empty) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_MUL;
      ST_MUL:   state_next = ST_DIV;
      ST_DIV:   if (dcnt == 5'd0) state_next = ST_EMIT;
      ST_EMIT:  state_next = (cnt == 4'd1) ? ST_IDLE : ST_SETUP;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_valid <= 1'b0;
    end else begin
      state        <= state_next;
      vertex_valid <= (state == ST_EMIT);
    end

    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          cur <= pop_data;
          dig <= pop_data.digits << {4'd15 - pop_data.len, 2'b00};
          cnt <= pop_data.len;
        end
      end
      ST_SETUP: begin
        num_r  <= num_c;
        den_r  <= den_a[mct_pkg::NUM_W-1:0];
        zero_r <= (den_a == 18'sd0);
        axis_r <= axis;
        lo_r   <= lo;
        unique case (axis)
          mct_pkg::AXIS_X: size_r <= cell_size_x;
          mct_pkg::AXIS_Y: size_r <= cell_size_y;
          default:         size_r <= cell_size_z;
        endcase
        dig <= dig << 4;
      end
      ST_MUL: begin
        // quotient fits in SIZE_W bits, so the top part is below den
        rem  <= prod[mct_pkg::PROD_W-1 -: mct_pkg::NUM_W];
        pr   <= prod[mct_pkg::SIZE_W-1:0];
        dcnt <= 5'(mct_pkg::SIZE_W - 1);
      end
      ST_DIV: begin
        rem  <= ge ? mct_pkg::NUM_W'(trial - {1'b0, den_r})
                   : trial[mct_pkg::NUM_W-1:0];
        pr   <= {pr[mct_pkg::SIZE_W-2:0], ge};
        dcnt <= dcnt - 5'd1;
      end
      ST_EMIT: begin
        vertex.vertex_x    <= vx;
        vertex.vertex_y    <= vy;
        vertex.vertex_z    <= vz;
        vertex.last_vertex <= (cnt == 4'd1);
        cnt                <= cnt - 4'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/marching_cubes_cell_triangulator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_cubes_cell_triangulator_core
// Marching-cubes cell triangulator: voxel cells in, triangle vertices out.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------
//  cell     | start, busy           | voxel (corners, voxel index, flag)
//  vertex   | vertex_valid (strobe) | vertex (x, y, z Q17.16, last)
//  config   | cfg_we                | cfg_index, cfg_data
//
//  A cell is taken each cycle while busy is low; cells that emit nothing
//  never raise busy. Each vertex goes through setup, multiply, 24 divide
//  steps of the one-bit-per-cycle divider and emit; the back end pops no
//  new cell until the last vertex of the current one has been emitted.
//  A two-entry queue sits between classification and interpolation.
//  Synchronous reset clears all control state; no clearing pass.
//  Vertices are strobed for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module marching_cubes_cell_triangulator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  mct_pkg::cell_t                    voxel,
  output logic                              vertex_valid,
  output mct_pkg::vertex_t                  vertex,
  input  logic                              cfg_we,
  input  logic [mct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mct_pkg::CFG_W-1:0]         cfg_data
);

  logic [mct_pkg::ISO_W-1:0]  iso_level;
  logic [mct_pkg::SIZE_W-1:0] cell_size_x;
  logic [mct_pkg::SIZE_W-1:0] cell_size_y;
  logic [mct_pkg::SIZE_W-1:0] cell_size_z;

  logic            push;
  mct_pkg::entry_t push_data;
  logic            pop;
  mct_pkg::entry_t pop_data;
  logic            full;
  logic            empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_level   <= mct_pkg::ISO_RESET;
      cell_size_x <= mct_pkg::SIZE_RESET;
      cell_size_y <= mct_pkg::SIZE_RESET;
      cell_size_z <= mct_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mct_pkg::REG_ISO_LEVEL:   iso_level   <= cfg_data[mct_pkg::ISO_W-1:0];
        mct_pkg::REG_CELL_SIZE_X: cell_size_x <= cfg_data;
        mct_pkg::REG_CELL_SIZE_Y: cell_size_y <= cfg_data;
        default:                  cell_size_z <= cfg_data;
      endcase
    end
  end

  mct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .voxel       (voxel),
    .busy        (busy),
    .iso_level   (iso_level),
    .cell_size_x (cell_size_x),
    .cell_size_y (cell_size_y),
    .cell_size_z (cell_size_z),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  mct_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  mct_back u_back (
    .clk          (clk),
    .rst          (rst),
    .iso_level    (iso_level),
    .cell_size_x  (cell_size_x),
    .cell_size_y  (cell_size_y),
    .cell_size_z  (cell_size_z),
    .empty        (empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .vertex_valid (vertex_valid),
    .vertex       (vertex)
  );

endmodule

// File: src/mct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mct_checker
// Port-level checks on the cell triangulator, bound to the top level.
// ----------------------------------------------------------------------------
module mct_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic vertex_valid
);

  // nothing pending right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!busy && !vertex_valid))
    else $error("busy or vertex strobe right after reset");

  // a stall only follows a request taken the cycle before
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // every vertex needs a full divide, strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    vertex_valid |=> !vertex_valid)
    else $error("vertex strobes in consecutive cycles");

endmodule

bind marching_cubes_cell_triangulator_core mct_checker u_mct_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .vertex_valid (vertex_valid)
);

// File: test/marching_cubes_cell_triangulator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// marching_cubes_cell_triangulator_core_tb
// Drives voxel cells through the triangulator under several register
// settings and checks every strobed vertex against an in-bench triangulator.
// ----------------------------------------------------------------------------
module marching_cubes_cell_triangulator_core_tb;

  localparam int N_RANDOM = 360;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  mct_pkg::cell_t                voxel = '0;
  logic                          vertex_valid;
  mct_pkg::vertex_t              vertex;
  logic                          cfg_we = 1'b0;
  logic [mct_pkg::CFG_IDX_W-1:0] cfg_index = mct_pkg::REG_ISO_LEVEL;
  logic [mct_pkg::CFG_W-1:0]     cfg_data = '0;

  marching_cubes_cell_triangulator_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .voxel(voxel),
    .vertex_valid(vertex_valid), .vertex(vertex),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // triangle list per corner mask, one hex digit per edge
  string tri_rows [256] = '{
    "","083","019","183981","12a","08312a","92a029","2832a8a98","3b2","0b28b0",
    "19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
    "478","430734","019847","419471731","12a847","34730412a","92a902847",
    "2a9297273794","8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784",
    "1ba14b1047b4","47890b9bab03","47b4b99ba",
    "954","954083","054150","854835315","12a954","30812a495","52a542402",
    "2a5325354348","95423b","0b208b495","05401523b","21525828b485","a3ba13954",
    "4950818a18ba","54050b5bab03","54858aa8b",
    "978579","930953573","078017157","153357","978957a12","a12950530573",
    "802825857a52","2a5253357","7957893b2","95797292027b","23b018178157",
    "b21b17715","958857a13a3b","5705097b010aba0","ba0b03a50807570","ba57b5",
    "a65","0835a6","9015a6","1831985a6","165261","165126308","965906026",
    "598582526328","23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513",
    "08b0b50515b6","3b6036065059","65969bb98",
    "5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347",
    "847905065026","739794329596269","3b2784a65","5a647242027b","01947823b5a6",
    "9219b294b7b45a6","8473b53515b6","51b5b610b7b404b","059065036b63847",
    "65969b4797b9",
    "a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264",
    "024426","832824426","a49a64b23","08228b49a4a6","3b201606461a",
    "64161a48121b8b1","964936913b63","8b1810b61914641","3b6360064","648b68",
    "7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867",
    "269291679093739","780706602","732672","23ba68a89867","20727b09767a9a7",
    "1801781a767a23b","b21b17a61671","896867916b63136","091b67","7807063b0b60",
    "7b6",
    "76b","308b76","019b76","819831b76","a1267b","12a3086b7","2902a96b7",
    "6b72a3a83a98","723627","708760620","276237019","162186198876","a76a17137",
    "a7617a187108","03707a0a96a7","76a7a88a9",
    "684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046",
    "4b846b0292a9","a93a32943b36463","823842462","042462","190234246438",
    "194142246","8138618466a1","a10a06604","4634386a3039a93","a946a4",
    "49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495",
    "76b54a42a402","348354325a52b76","723762549","954086062687","362376150540",
    "628687218485158","954a16176137","16a176107870954","40a4a503a6a737a",
    "76a7a854a48a",
    "6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56",
    "0b306b09656912a","b85b56805a52025","6b36352a3a53","589528562382",
    "956960062","158180568382628","156216","13616a386569896","a10a06950560",
    "03856a","a56",
    "b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b71751","08312717572b",
    "9759279022b7","75272b592328982","25a235375","820852875a25","9015a35373a2",
    "982921872a25752","135375","087071175","903935537","987597",
    "5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
    "04b0b345b2b151b","0250592b5458b85","9452b3","25a352345384","5a2524420",
    "3a235a385458019","5a2524192942","845853351","045105","845853905035","945",
    "4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
    "9749b791b2b1083","b74b42240","b74b42834324","29a279237749",
    "9a7974a27870207","37a3a274a1a040a","1a2874","491417713","491417081871",
    "403743","487",
    "9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9",
    "02b80b","32b","23828aa89","9a2092","23828a0181a8","1a2","138918","091",
    "038",""
  };

  // edge endpoints as numbered in the triangle rows
  int edge_from [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
  int edge_to   [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

  // register shadow, updated as the block sees writes
  logic [mct_pkg::ISO_W-1:0]  iso_q;
  logic [mct_pkg::SIZE_W-1:0] size_q [3];

  typedef struct {
    mct_pkg::cell_t c;
    int             want_n;   // -1: count from the predictor only
  } row_t;

  row_t             dir_rows [$];
  mct_pkg::vertex_t expected_vertices [$];
  int      cells_accepted = 0;
  int      vertices_seen = 0;
  int      mismatches = 0;
  int      busy_cells = 0;
  int      last_n = 0;

  function automatic bit [2:0] corner_pos(input int c);
    return {c[1], c[2], c[0] ^ c[1]};  // {z, y, x}
  endfunction

  function automatic longint unsigned crossing(input longint unsigned size,
                                               input longint lo_v, input longint hi_v);
    longint num, den;
    num = longint'(iso_q) - lo_v;
    den = hi_v - lo_v;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (den == 0) return 0;
    if (num < 0) num = 0;
    if (num > den) num = den;
    return (size * longint'(num)) / longint'(den);
  endfunction

  function automatic int triangulate_cell(input mct_pkg::cell_t c);
    longint            v [8];
    logic [7:0]        mask;
    longint unsigned   base [3], pos [3];
    bit [2:0]          pa, pb, plo, phi;
    int                a, b, lo, hi, e, n, ax;
    byte               ch;
    mct_pkg::vertex_t  vt;
    if (!c.all_observed) return 0;
    if (c.voxel_x >= mct_pkg::MAX_RES || c.voxel_y >= mct_pkg::MAX_RES ||
        c.voxel_z >= mct_pkg::MAX_RES) return 0;
    v = '{c.corner_0, c.corner_1, c.corner_2, c.corner_3,
          c.corner_4, c.corner_5, c.corner_6, c.corner_7};
    for (int i = 0; i < 8; i++) mask[i] = v[i] < longint'(iso_q);
    base[0] = longint'(c.voxel_x) * size_q[0];
    base[1] = longint'(c.voxel_y) * size_q[1];
    base[2] = longint'(c.voxel_z) * size_q[2];
    n = tri_rows[mask].len();
    for (int k = 0; k < n; k++) begin
      ch = tri_rows[mask].getc(k);
      e = (ch >= "a") ? ch - "a" + 10 : ch - "0";
      a = edge_from[e];
      b = edge_to[e];
      pa = corner_pos(a);
      pb = corner_pos(b);
      lo = ((pa & ~pb) != 0) ? b : a;
      hi = (lo == a) ? b : a;
      plo = corner_pos(lo);
      phi = corner_pos(hi);
      for (int i = 0; i < 3; i++) begin
        pos[i] = base[i] + (plo[i] ? size_q[i] : 0);
        if (plo[i] != phi[i]) ax = i;
      end
      pos[ax] += crossing(size_q[ax], v[lo], v[hi]);
      vt.vertex_x = pos[0][mct_pkg::COORD_W-1:0];
      vt.vertex_y = pos[1][mct_pkg::COORD_W-1:0];
      vt.vertex_z = pos[2][mct_pkg::COORD_W-1:0];
      vt.last_vertex = (k == n - 1);
      expected_vertices = {expected_vertices, vt};
    end
    return n;
  endfunction

  // sample everything at the rising edge
  always @(posedge clk) begin
    mct_pkg::vertex_t want;
    if (rst) begin
      iso_q = mct_pkg::ISO_RESET;
      size_q = '{mct_pkg::SIZE_RESET, mct_pkg::SIZE_RESET, mct_pkg::SIZE_RESET};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mct_pkg::REG_ISO_LEVEL:   iso_q = cfg_data[mct_pkg::ISO_W-1:0];
          mct_pkg::REG_CELL_SIZE_X: size_q[0] = cfg_data;
          mct_pkg::REG_CELL_SIZE_Y: size_q[1] = cfg_data;
          default:                  size_q[2] = cfg_data;
        endcase
      end
      if (vertex_valid) begin
        vertices_seen++;
        if (expected_vertices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected vertex %p", vertex);
        end else begin
          want = expected_vertices.pop_front();
          if (vertex !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("vertex mismatch: exp x=%h y=%h z=%h last=%b got x=%h y=%h z=%h last=%b",
                       want.vertex_x, want.vertex_y, want.vertex_z, want.last_vertex,
                       vertex.vertex_x, vertex.vertex_y, vertex.vertex_z, vertex.last_vertex);
          end
        end
      end
      if (start && !busy) begin
        cells_accepted++;
        last_n = triangulate_cell(voxel);
        if (last_n > 0) busy_cells++;
      end
    end
  end

  task automatic send_cell(input mct_pkg::cell_t c);
    int target;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    voxel = c;
    start = 1'b1;
    target = cells_accepted + 1;
    do @(negedge clk); while (cells_accepted < target);
  endtask

  task automatic drain;
    start = 1'b0;
    while (expected_vertices.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic [mct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mct_pkg::CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic mct_pkg::cell_t random_cell;
    mct_pkg::cell_t c;
    logic [15:0] s [8];
    int kind;
    kind = $urandom_range(0, 19);
    for (int i = 0; i < 8; i++) begin
      case (kind % 4)
        0: s[i] = 16'($urandom);                                     // noise
        1: s[i] = 16'(iso_q + $urandom_range(0, 64) - 32);           // near the surface
        2: s[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;      // extremes
        default: s[i] = 16'($urandom_range(0, 32767) - 8192);
      endcase
    end
    {c.corner_0, c.corner_1, c.corner_2, c.corner_3,
     c.corner_4, c.corner_5, c.corner_6, c.corner_7} = {s[0], s[1], s[2], s[3],
                                                        s[4], s[5], s[6], s[7]};
    c.voxel_x = 9'($urandom);
    c.voxel_y = 9'($urandom);
    c.voxel_z = 9'($urandom);
    c.all_observed = (kind != 0 || $urandom_range(0, 1));
    return c;
  endfunction

  function automatic mct_pkg::cell_t mk(input int c0, c1, c2, c3, c4, c5, c6, c7,
                                        input int x, y, z, input bit obs);
    mct_pkg::cell_t c;
    c = '{16'(c0), 16'(c1), 16'(c2), 16'(c3), 16'(c4), 16'(c5), 16'(c6), 16'(c7),
          9'(x), 9'(y), 9'(z), obs};
    return c;
  endfunction

  function automatic void add_row(input mct_pkg::cell_t c, input int want_n);
    row_t r;
    r.c = c;
    r.want_n = want_n;
    dir_rows = {dir_rows, r};
  endfunction

  initial begin
    int   phase_iso [4];
    logic [mct_pkg::SIZE_W-1:0] phase_size [4];
    // unobserved, uniform above and below, single corners, extremes
    add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1, 1, 2, 3, 0), 0);
    add_row(mk(5, 5, 5, 5, 5, 5, 5, 5, 0, 0, 0, 1), 0);
    add_row(mk(-1, -1, -1, -1, -1, -1, -1, -1, 0, 0, 0, 1), 0);
    add_row(mk(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
               0, 0, 0, 1), 3);
    add_row(mk(32767, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
               511, 511, 511, 1), 3);
    add_row(mk(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
               511, 0, 511, 1), -1);
    add_row(mk(-16384, 16384, -16384, 16384, 16384, -16384, 16384, -16384,
               7, 9, 11, 1), 12);
    add_row(mk(-100, 100, 100, 100, 100, 100, 100, 100, 3, 3, 3, 1), 3);
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 2, 2, 2, 1), 0);
    add_row(mk(-1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1), 3);
    for (int i = 0; i < 8; i++)
      add_row(mk(i == 0 ? 0 : 200, i == 1 ? -300 : 200, i == 2 ? -1 : 200,
                 i == 3 ? -32768 : 200, i == 4 ? -5 : 200, i == 5 ? -7 : 200,
                 i == 6 ? -9 : 200, i == 7 ? -16384 : 200, i, 8 - i, 2 * i, 1),
              i == 0 ? 0 : 3);
    add_row(mk(-5, 5, -5, 5, -5, 5, -5, 5, 100, 200, 300, 1), -1);
    add_row(mk(-9, 9, 9, -9, 9, -9, -9, 9, 10, 20, 30, 1), -1);

    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_cell(dir_rows[i].c);
      if (dir_rows[i].want_n >= 0 && last_n != dir_rows[i].want_n) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: exp %0d vertices got %0d", i, dir_rows[i].want_n, last_n);
      end
    end
    drain();

    phase_iso  = '{16383, 0, 8192, 0};
    phase_size = '{24'hFFFFFF, 24'h000000, 24'h010000, 24'h000000};
    for (int p = 0; p < 4; p++) begin
      logic [mct_pkg::CFG_W-1:0] iso_word;
      iso_word = (p == 3) ? mct_pkg::CFG_W'($urandom) :
                 {10'($urandom_range(0, 1023)), 14'(phase_iso[p])};
      write_reg(mct_pkg::REG_ISO_LEVEL, iso_word);
      write_reg(mct_pkg::REG_CELL_SIZE_X,
                p == 3 ? mct_pkg::CFG_W'($urandom) : phase_size[p]);
      write_reg(mct_pkg::REG_CELL_SIZE_Y,
                p == 3 ? mct_pkg::CFG_W'($urandom) : phase_size[p]);
      write_reg(mct_pkg::REG_CELL_SIZE_Z,
                p == 3 ? mct_pkg::CFG_W'($urandom_range(0, 255)) : phase_size[p]);
      for (int k = 0; k < N_RANDOM / 4; k++) send_cell(random_cell());
      drain();
    end

    $display("%0d cells accepted (%0d with a surface), %0d vertices checked, %0d mismatches",
             cells_accepted, busy_cells, vertices_seen, mismatches);
    $display("register settings: reset, full scale, zero size, mid iso, random");
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
src/mct_pkg.sv
src/mct_front.sv
src/mct_fifo.sv
src/mct_back.sv
src/marching_cubes_cell_triangulator_core.sv
src/mct_checker.sv
test/marching_cubes_cell_triangulator_core_tb.sv
